// ----- hdl/bfbs_pkg.sv -----
// ----------------------------------------------------------------------------
// bfbs_pkg
// Shared item types and codes of the best-fit block suballocator.
// ----------------------------------------------------------------------------
package bfbs_pkg;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic [1:0] ST_PLACED   = 2'd0;
	localparam logic [1:0] ST_NEW_BLK  = 2'd1;
	localparam logic [1:0] ST_FULL     = 2'd2;
	localparam logic [1:0] ST_NOT_FND  = 2'd3;

	typedef struct packed {
		logic        func;
		logic [47:0] req_size;
		logic [4:0]  align_log2;
		logic [3:0]  free_block;
		logic [47:0] free_offset;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  block_index;
		logic [47:0] alloc_offset;
		logic [47:0] opened_size;
	} rsp_t;

endpackage

// ----- hdl/bfbs_ram.sv -----
// ----------------------------------------------------------------------------
// bfbs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bfbs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- hdl/bfbs_fit.sv -----
// ----------------------------------------------------------------------------
// bfbs_fit
// Two-stage fit evaluator: aligned start and segment end, then need and leftover.
// ----------------------------------------------------------------------------
module bfbs_fit #(
	parameter int SIZE_BITS = 48,
	parameter int IW        = 6,
	parameter int EW        = 50
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 flush,
	input  logic                 in_v,
	input  logic [IW-1:0]        in_idx,
	input  logic [SIZE_BITS-1:0] in_off,
	input  logic [SIZE_BITS-1:0] in_sz,
	input  logic [EW-1:0]        msk,
	input  logic [SIZE_BITS-1:0] req,
	output logic                 c_v,
	output logic [IW-1:0]        c_idx,
	output logic [EW-1:0]        c_alo,
	output logic [EW-1:0]        c_left,
	output logic                 c_fits,
	output logic                 busy
);

	logic          v_s1, v_s2;
	logic [IW-1:0] idx_s1, idx_s2;
	logic [EW-1:0] alo_s1, end_s1, alo_s2, need_s2, end_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= in_v & ~flush;
			v_s2 <= v_s1 & ~flush;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= in_idx;
		alo_s1  <= (EW'(in_off) + msk) & ~msk;
		end_s1  <= EW'(in_off) + EW'(in_sz);
		idx_s2  <= idx_s1;
		alo_s2  <= alo_s1;
		end_s2  <= end_s1;
		need_s2 <= alo_s1 + EW'(req);
	end

	assign c_v    = v_s2;
	assign c_idx  = idx_s2;
	assign c_alo  = alo_s2;
	assign c_fits = end_s2 >= need_s2;
	assign c_left = end_s2 - need_s2;
	assign busy   = v_s1 | v_s2;

endmodule

// ----- hdl/best_fit_block_suballocator.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_suballocator
// Best-fit suballocator over a linked segment table held in one RAM.
// ----------------------------------------------------------------------------
// Allocate: walks the entries, one read per cycle (RAM read port bound), then
// drains the fit pipeline, decides, claims up to two entries and writes up to
// three records; a new block reuses the tail of the walk.
// Free: walks to the match; a hit adds the merge steps. The done strobe follows.
// One item at a time; the result is shown one cycle on done, never stalled.
// Reset clears valid bits, head and block count, presets the register; no clearing pass.
module best_fit_block_suballocator #(
	parameter int MAX_SEGMENTS = 64,
	parameter int MAX_BLOCKS   = 16,
	parameter int SIZE_BITS    = 48
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  bfbs_pkg::req_t  item,
	output logic            done,
	output bfbs_pkg::rsp_t  result,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [47:0]     cfg_data
);

	localparam int IW    = $clog2(MAX_SEGMENTS);
	localparam int FW    = $clog2(MAX_SEGMENTS + 1);
	localparam int BLK_W = $clog2(MAX_BLOCKS + 1);
	localparam int BCW   = (BLK_W > 4) ? BLK_W : 4;
	localparam int EW    = ((SIZE_BITS > 31) ? SIZE_BITS : 31) + 2;
	localparam int S     = SIZE_BITS;

	// sequencer states
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_AWALK  = 4'd1;
	localparam logic [3:0] S_ADRAIN = 4'd2;
	localparam logic [3:0] S_ADEC   = 4'd3;
	localparam logic [3:0] S_ABEST  = 4'd4;
	localparam logic [3:0] S_AGET   = 4'd5;
	localparam logic [3:0] S_ABUILD = 4'd6;
	localparam logic [3:0] S_AWRITE = 4'd7;
	localparam logic [3:0] S_FWALK  = 4'd8;
	localparam logic [3:0] S_FNX    = 4'd9;
	localparam logic [3:0] S_FMRG   = 4'd10;

	typedef struct packed {
		logic [BLK_W-1:0] blk;
		logic [S-1:0]     off;
		logic [S-1:0]     size;
		logic             used;
		logic [IW-1:0]    nxt;
	} rec_t;

	function automatic rec_t mk(input logic [BLK_W-1:0] b, input logic [S-1:0] o,
		input logic [S-1:0] z, input logic u);
		rec_t r;
		r.blk  = b;
		r.off  = o;
		r.size = z;
		r.used = u;
		r.nxt  = '0;
		return r;
	endfunction

	// control state
	logic [3:0]              st_q;
	logic [IW-1:0]           head_q, cur_q;
	logic [BLK_W-1:0]        bcnt_q;
	logic [MAX_SEGMENTS-1:0] valid_q;
	logic [FW-1:0]           free_q;
	logic [S-1:0]            dflt_q;
	logic                    found_q, new_q, hasp_q, done_q;
	logic [1:0]              need_q, k_q, wk_q, wcnt_q;

	// item and working registers
	logic [S-1:0]     req_q, fo_q, pre_q, suf_q, bsz_q;
	logic [3:0]       fb_q;
	logic [EW-1:0]    msk_q, best_left_q, best_alo_q;
	logic [IW-1:0]    best_idx_q, tail_q, xa_q, xb_q, prev_q;
	rec_t             be_q, tail_rec_q, cur_rec_q, prev_rec_q;
	logic [IW-1:0]    wa_q [3];
	rec_t             wd_q [3];
	bfbs_pkg::rsp_t   res_q, pend_q;

	// RAM
	logic          we;
	logic [IW-1:0] waddr, raddr;
	rec_t          wdata, rd;

	bfbs_ram #(.WIDTH($bits(rec_t)), .DEPTH(MAX_SEGMENTS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd)
	);

	// fit pipeline
	logic          walk_on, fit_v, fit_fits, fit_busy, upd, exact;
	logic [IW-1:0] fit_idx;
	logic [EW-1:0] fit_alo, fit_left;

	assign walk_on = (st_q == S_AWALK) || (st_q == S_ADRAIN);

	bfbs_fit #(.SIZE_BITS(S), .IW(IW), .EW(EW)) u_fit (
		.clk    (clk),
		.arst_n (arst_n),
		.flush  (!walk_on),
		.in_v   ((st_q == S_AWALK) && !rd.used),
		.in_idx (cur_q),
		.in_off (rd.off),
		.in_sz  (rd.size),
		.msk    (msk_q),
		.req    (req_q),
		.c_v    (fit_v),
		.c_idx  (fit_idx),
		.c_alo  (fit_alo),
		.c_left (fit_left),
		.c_fits (fit_fits),
		.busy   (fit_busy)
	);

	// strictly better keeps the first on ties
	assign upd   = walk_on && fit_v && fit_fits && (!found_q || fit_left < best_left_q);
	assign exact = upd && (fit_left == '0);

	// lowest free entry
	logic [IW-1:0] ff;
	always_comb begin
		ff = '0;
		for (int i = MAX_SEGMENTS - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				ff = IW'(i);
			end
		end
	end

	// split / new-block decision values
	logic [S-1:0] pre_w, suf_w, bsz_w, nsuf_w;
	logic [1:0]   need_w, nneed_w;
	assign pre_w   = S'(best_alo_q) - rd.off;
	assign suf_w   = S'(best_left_q);
	assign need_w  = {1'b0, pre_w != '0} + {1'b0, suf_w != '0};
	assign bsz_w   = (req_q > dflt_q) ? req_q : dflt_q;
	assign nsuf_w  = bsz_w - req_q;
	assign nneed_w = 2'd1 + {1'b0, nsuf_w != '0};

	// chain builder: up to three records, linked in order
	logic [IW-1:0]   ba [3];
	rec_t            bd [3];
	logic [1:0]      scnt;
	logic            lastself;
	logic [IW-1:0]   bn;
	logic [S-1:0]    alo_s, aend_s;
	logic [BLK_W-1:0] nb;
	bfbs_pkg::rsp_t  pend_w;

	always_comb begin
		alo_s    = S'(best_alo_q);
		aend_s   = alo_s + req_q;
		nb       = bcnt_q;
		ba[0]    = best_idx_q;
		ba[1]    = xa_q;
		ba[2]    = xb_q;
		bd[0]    = mk(be_q.blk, alo_s, req_q, 1'b1);
		bd[1]    = mk(be_q.blk, aend_s, suf_q, 1'b0);
		bd[2]    = mk(be_q.blk, aend_s, suf_q, 1'b0);
		scnt     = need_q + 2'd1;
		lastself = (be_q.nxt == best_idx_q);
		bn       = be_q.nxt;
		pend_w.status       = bfbs_pkg::ST_PLACED;
		pend_w.block_index  = 4'(be_q.blk);
		pend_w.alloc_offset = 48'(alo_s);
		pend_w.opened_size  = '0;
		if (!new_q) begin
			if (pre_q != '0) begin
				bd[0] = mk(be_q.blk, be_q.off, pre_q, 1'b0);
				bd[1] = mk(be_q.blk, alo_s, req_q, 1'b1);
			end
		end else begin
			lastself = 1'b1;
			bn       = '0;
			pend_w.status       = bfbs_pkg::ST_NEW_BLK;
			pend_w.block_index  = 4'(nb);
			pend_w.alloc_offset = '0;
			pend_w.opened_size  = 48'(bsz_q);
			if (bcnt_q != '0) begin
				ba[0] = tail_q;
				bd[0] = tail_rec_q;
				bd[1] = mk(nb, '0, req_q, 1'b1);
				bd[2] = mk(nb, req_q, suf_q, 1'b0);
			end else begin
				ba[0] = xa_q;
				ba[1] = xb_q;
				bd[0] = mk(nb, '0, req_q, 1'b1);
				bd[1] = mk(nb, req_q, suf_q, 1'b0);
				scnt  = need_q;
			end
		end
		bd[0].nxt = (scnt == 2'd1) ? (lastself ? ba[0] : bn) : ba[1];
		bd[1].nxt = (scnt == 2'd2) ? (lastself ? ba[1] : bn) : ba[2];
		bd[2].nxt = lastself ? ba[2] : bn;
	end

	// free path merge values
	logic [IW-1:0] nx;
	logic          merge_n, merge_p;
	rec_t          cur_m;
	assign nx      = cur_rec_q.nxt;
	assign merge_n = (nx != cur_q) && valid_q[nx] && !rd.used
		&& (BCW'(rd.blk) == BCW'(fb_q));
	assign merge_p = hasp_q && !prev_rec_q.used && (BCW'(prev_rec_q.blk) == BCW'(fb_q));

	always_comb begin
		cur_m      = cur_rec_q;
		cur_m.used = 1'b0;
		if (merge_n) begin
			cur_m.size = cur_rec_q.size + rd.size;
			cur_m.nxt  = (rd.nxt == nx) ? cur_q : rd.nxt;
		end
	end

	logic fhit;
	assign fhit = rd.used && (BCW'(rd.blk) == BCW'(fb_q)) && (rd.off == fo_q);

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = wa_q[wk_q];
		wdata = wd_q[wk_q];
		raddr = rd.nxt;
		unique case (st_q)
			S_IDLE:   raddr = head_q;
			S_ADEC:   raddr = best_idx_q;
			S_AWRITE: we = 1'b1;
			S_FMRG: begin
				we = 1'b1;
				if (merge_p) begin
					waddr          = prev_q;
					wdata          = prev_rec_q;
					wdata.size     = prev_rec_q.size + cur_rec_q.size;
					wdata.nxt      = (cur_rec_q.nxt == cur_q) ? prev_q : cur_rec_q.nxt;
				end else begin
					waddr = cur_q;
					wdata = cur_rec_q;
				end
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_IDLE;
			head_q  <= '0;
			bcnt_q  <= '0;
			valid_q <= '0;
			free_q  <= FW'(MAX_SEGMENTS);
			dflt_q  <= S'(48'd268435456);
			found_q <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				dflt_q <= S'(cfg_data);
			end
			unique case (st_q)
				S_IDLE: begin
					if (start) begin
						found_q <= 1'b0;
						hasp_q  <= 1'b0;
						cur_q   <= head_q;
						if (item.func == bfbs_pkg::FUNC_ALLOC) begin
							st_q <= (bcnt_q != '0) ? S_AWALK : S_ADEC;
						end else if (bcnt_q != '0) begin
							st_q <= S_FWALK;
						end else begin
							res_q.status       <= bfbs_pkg::ST_NOT_FND;
							res_q.block_index  <= item.free_block;
							res_q.alloc_offset <= 48'(S'(item.free_offset));
							res_q.opened_size  <= '0;
							done_q             <= 1'b1;
						end
					end
				end
				S_AWALK: begin
					if (exact) begin
						st_q <= S_ADEC;
					end else if (rd.nxt == cur_q) begin
						tail_q     <= cur_q;
						tail_rec_q <= rd;
						st_q       <= S_ADRAIN;
					end else begin
						cur_q <= rd.nxt;
					end
				end
				S_ADRAIN: begin
					if (exact || !fit_busy) begin
						st_q <= S_ADEC;
					end
				end
				S_ADEC: begin
					k_q <= '0;
					if (found_q) begin
						st_q <= S_ABEST;
					end else if (bcnt_q >= BLK_W'(MAX_BLOCKS) || free_q < FW'(nneed_w)) begin
						res_q  <= '{bfbs_pkg::ST_FULL, 4'd0, 48'd0, 48'd0};
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else begin
						new_q  <= 1'b1;
						bsz_q  <= bsz_w;
						suf_q  <= nsuf_w;
						need_q <= nneed_w;
						st_q   <= S_AGET;
					end
				end
				S_ABEST: begin
					new_q  <= 1'b0;
					be_q   <= rd;
					pre_q  <= pre_w;
					suf_q  <= suf_w;
					need_q <= need_w;
					if (free_q < FW'(need_w)) begin
						res_q  <= '{bfbs_pkg::ST_FULL, 4'd0, 48'd0, 48'd0};
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else begin
						st_q <= (need_w == 2'd0) ? S_ABUILD : S_AGET;
					end
				end
				S_AGET: begin
					if (k_q == 2'd0) begin
						xa_q <= ff;
					end else begin
						xb_q <= ff;
					end
					valid_q[ff] <= 1'b1;
					free_q      <= free_q - FW'(1);
					k_q         <= k_q + 2'd1;
					if (k_q + 2'd1 == need_q) begin
						st_q <= S_ABUILD;
					end
				end
				S_ABUILD: begin
					for (int i = 0; i < 3; i++) begin
						wa_q[i] <= ba[i];
						wd_q[i] <= bd[i];
					end
					wcnt_q <= scnt;
					wk_q   <= '0;
					pend_q <= pend_w;
					if (new_q) begin
						bcnt_q <= bcnt_q + BLK_W'(1);
						if (bcnt_q == '0) begin
							head_q <= xa_q;
						end
					end
					st_q <= S_AWRITE;
				end
				S_AWRITE: begin
					wk_q <= wk_q + 2'd1;
					if (wk_q == wcnt_q - 2'd1) begin
						res_q  <= pend_q;
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end
				end
				S_FWALK: begin
					if (fhit) begin
						cur_rec_q <= rd;
						st_q      <= S_FNX;
					end else if (rd.nxt == cur_q) begin
						res_q  <= '{bfbs_pkg::ST_NOT_FND, fb_q, 48'(fo_q), 48'd0};
						done_q <= 1'b1;
						st_q   <= S_IDLE;
					end else begin
						prev_q     <= cur_q;
						prev_rec_q <= rd;
						hasp_q     <= 1'b1;
						cur_q      <= rd.nxt;
					end
				end
				S_FNX: begin
					cur_rec_q <= cur_m;
					if (merge_n) begin
						valid_q[nx] <= 1'b0;
						free_q      <= free_q + FW'(1);
					end
					st_q <= S_FMRG;
				end
				S_FMRG: begin
					if (merge_p) begin
						valid_q[cur_q] <= 1'b0;
						free_q         <= free_q + FW'(1);
					end
					res_q  <= '{bfbs_pkg::ST_PLACED, fb_q, 48'(fo_q), 48'd0};
					done_q <= 1'b1;
					st_q   <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			if (upd) begin
				found_q     <= 1'b1;
				best_idx_q  <= fit_idx;
				best_left_q <= fit_left;
				best_alo_q  <= fit_alo;
			end
		end
	end

	// item capture, no reset needed
	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && start) begin
			req_q <= S'(item.req_size);
			msk_q <= (EW'(1) << item.align_log2) - EW'(1);
			fb_q  <= item.free_block;
			fo_q  <= S'(item.free_offset);
		end
	end

	assign busy      = (st_q != S_IDLE);
	assign done      = done_q;
	assign result    = res_q;
	assign cfg_ready = 1'b1;

endmodule

// ----- hdl/bfbs_chk.sv -----
// ----------------------------------------------------------------------------
// bfbs_chk
// Port-level checks of the suballocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfbs_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input bfbs_pkg::req_t item,
	input logic           done,
	input bfbs_pkg::rsp_t result,
	input logic           cfg_valid,
	input logic           cfg_ready,
	input logic [47:0]    cfg_data
);

	// every result follows an accepted item or work in progress
	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(busy) || $past(start && !busy)))
		else $error("result without item");

	// an accepted item keeps the block busy or answers at once
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("item dropped");

	// table full reports zero block index, offset and block size
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == bfbs_pkg::ST_FULL) |->
		(result.block_index == 4'd0 && result.alloc_offset == 48'd0
			&& result.opened_size == 48'd0))
		else $error("full result not cleared");

	// only a new block reports a block size
	a_nbs: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != bfbs_pkg::ST_NEW_BLK) |-> (result.opened_size == 48'd0))
		else $error("block size without new block");

endmodule

bind best_fit_block_suballocator bfbs_chk u_bfbs_chk (.*);

// ----- sim/best_fit_block_suballocator_chk.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_suballocator_chk
// Watches request, result and register channels, predicts each result from a
// private copy of the segment table and compares it field by field.
// ----------------------------------------------------------------------------
module best_fit_block_suballocator_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  bfbs_pkg::req_t item,
	input  logic           done,
	input  bfbs_pkg::rsp_t result,
	input  logic           cfg_valid,
	input  logic           cfg_ready,
	input  logic [47:0]    cfg_data,
	output int             fail_count,
	output int             pending,
	output int             rsp_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NSEG = 64;
	localparam int NBLK = 16;

	logic [47:0]    min_blk_size;
	logic [3:0]     t_blk  [NSEG];
	logic [47:0]    t_off  [NSEG];
	logic [47:0]    t_size [NSEG];
	logic           t_used [NSEG];
	logic           t_val  [NSEG];
	int             t_next [NSEG];
	int             head;
	int             open_blocks;
	bfbs_pkg::rsp_t expected_q[$];

	function automatic int unused_entries();
		int n;
		n = 0;
		for (int i = 0; i < NSEG; i++)
			if (!t_val[i]) n++;
		return n;
	endfunction

	function automatic int first_unused();
		for (int i = 0; i < NSEG; i++)
			if (!t_val[i]) return i;
		return 0;
	endfunction

	function automatic void fill(int e, logic [3:0] b, logic [47:0] o, logic [47:0] s,
		logic u);
		t_blk[e] = b; t_off[e] = o; t_size[e] = s; t_used[e] = u; t_val[e] = 1'b1;
	endfunction

	function automatic int link_after(int x, logic [3:0] b, logic [47:0] o,
		logic [47:0] s, logic u);
		int e;
		e = first_unused();
		fill(e, b, o, s, u);
		t_next[e] = (t_next[x] == x) ? e : t_next[x];
		t_next[x] = e;
		return e;
	endfunction

	function automatic void unlink(int p, int r);
		t_next[p] = (t_next[r] == r) ? p : t_next[r];
		t_val[r] = 1'b0;
	endfunction

	function automatic bfbs_pkg::rsp_t place(logic [47:0] req, logic [4:0] al);
		bfbs_pkg::rsp_t r;
		logic [63:0] a, off, sz, alo, left, best, balo, pre, suf, bsz;
		bit found;
		int be, cur, at, e, tail, need;
		logic [3:0] b;
		r = '0; found = 0; be = 0; best = 0; balo = 0;
		a = 64'd1 << al;
		if (open_blocks > 0) begin
			cur = head;
			for (int s = 0; s < NSEG && t_val[cur]; s++) begin
				if (!t_used[cur]) begin
					off = 64'(t_off[cur]); sz = 64'(t_size[cur]);
					alo = (off + (a - 1)) & ~(a - 1);
					// aligned start past the 48-bit range never fits
					if (alo <= 64'hFFFF_FFFF_FFFF && alo - off <= sz
						&& 64'(req) <= sz - (alo - off)) begin
						left = sz - (alo - off) - 64'(req);
						if (!found || left < best) begin
							found = 1; be = cur; best = left; balo = alo;
							if (left == 0) break;
						end
					end
				end
				if (t_next[cur] == cur) break;
				cur = t_next[cur];
			end
		end
		if (found) begin
			off = 64'(t_off[be]); sz = 64'(t_size[be]); b = t_blk[be];
			pre = balo - off; suf = sz - pre - 64'(req);
			need = (pre != 0) + (suf != 0);
			if (unused_entries() < need) begin
				r.status = bfbs_pkg::ST_FULL;
				return r;
			end
			at = be;
			if (pre != 0) begin
				fill(be, b, 48'(off), 48'(pre), 1'b0);
				at = link_after(be, b, 48'(balo), req, 1'b1);
			end else begin
				fill(be, b, 48'(balo), req, 1'b1);
			end
			if (suf != 0) void'(link_after(at, b, 48'(balo + 64'(req)), 48'(suf), 1'b0));
			r.status = bfbs_pkg::ST_PLACED; r.block_index = b; r.alloc_offset = 48'(balo);
			return r;
		end
		bsz = (req > min_blk_size) ? 64'(req) : 64'(min_blk_size);
		suf = bsz - 64'(req);
		need = 1 + (suf != 0);
		if (open_blocks >= NBLK || unused_entries() < need) begin
			r.status = bfbs_pkg::ST_FULL;
			return r;
		end
		b = 4'(open_blocks);
		if (open_blocks == 0) begin
			e = first_unused();
			fill(e, b, '0, req, 1'b1);
			t_next[e] = e;
			head = e;
		end else begin
			tail = head;
			for (int s = 0; s < NSEG && t_next[tail] != tail; s++) tail = t_next[tail];
			e = link_after(tail, b, '0, req, 1'b1);
		end
		if (suf != 0) void'(link_after(e, b, req, 48'(suf), 1'b0));
		open_blocks++;
		r.status = bfbs_pkg::ST_NEW_BLK; r.block_index = b; r.opened_size = 48'(bsz);
		return r;
	endfunction

	function automatic bfbs_pkg::rsp_t release_seg(logic [3:0] fb, logic [47:0] fo);
		bfbs_pkg::rsp_t r;
		int cur, prv, nx;
		bit has_prv, hit;
		r = '0; r.block_index = fb; r.alloc_offset = fo;
		cur = head; prv = 0; has_prv = 0; hit = 0;
		if (open_blocks > 0) begin
			for (int s = 0; s < NSEG && t_val[cur]; s++) begin
				if (t_used[cur] && t_blk[cur] == fb && t_off[cur] == fo) begin
					hit = 1;
					break;
				end
				if (t_next[cur] == cur) break;
				prv = cur; has_prv = 1;
				cur = t_next[cur];
			end
		end
		if (!hit) begin
			r.status = bfbs_pkg::ST_NOT_FND;
			return r;
		end
		t_used[cur] = 1'b0;
		nx = t_next[cur];
		if (nx != cur && t_val[nx] && !t_used[nx] && t_blk[nx] == fb) begin
			t_size[cur] = t_size[cur] + t_size[nx];
			unlink(cur, nx);
		end
		if (has_prv && !t_used[prv] && t_blk[prv] == fb) begin
			t_size[prv] = t_size[prv] + t_size[cur];
			unlink(prv, cur);
		end
		r.status = bfbs_pkg::ST_PLACED;
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("MISMATCH %s: got %0h expected %0h", what, got, want);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		bfbs_pkg::rsp_t w;
		bfbs_pkg::rsp_t p;
		if (!arst_n) begin
			min_blk_size <= 48'd268435456;
			for (int i = 0; i < NSEG; i++) t_val[i] = 1'b0;
			head = 0; open_blocks = 0;
			expected_q.delete();
			pending = 0;
			fail_count = 0; rsp_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) min_blk_size <= cfg_data;
			if (done) begin
				rsp_seen++;
				if (expected_q.size() == 0) begin
					report("unexpected result", 64'(result.status), 64'd0);
				end else begin
					w = expected_q.pop_front();
					if (result.status !== w.status)
						report("status", 64'(result.status), 64'(w.status));
					if (result.block_index !== w.block_index)
						report("block_index", 64'(result.block_index), 64'(w.block_index));
					if (result.alloc_offset !== w.alloc_offset)
						report("alloc_offset", 64'(result.alloc_offset),
							64'(w.alloc_offset));
					if (result.opened_size !== w.opened_size)
						report("opened_size", 64'(result.opened_size), 64'(w.opened_size));
				end
			end
			if (start && !busy) begin
				p = (item.func == bfbs_pkg::FUNC_FREE)
					? release_seg(item.free_block, item.free_offset)
					: place(item.req_size, item.align_log2);
				expected_q.insert(expected_q.size(), p);
			end
			pending = expected_q.size();
		end
	end
endmodule

// ----- sim/best_fit_block_suballocator_tb.sv -----
// ----------------------------------------------------------------------------
// best_fit_block_suballocator_tb
// Drives allocate/free requests and register writes into the suballocator;
// the checker beside it predicts and compares every result.
// ----------------------------------------------------------------------------
module best_fit_block_suballocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIMIT_CYCLES = 600000;

	logic           clk;
	logic           arst_n;
	logic           start;
	logic           busy;
	bfbs_pkg::req_t item;
	logic           done;
	bfbs_pkg::rsp_t result;
	logic           cfg_valid;
	logic           cfg_ready;
	logic [47:0]    cfg_data;
	int             fail_count;
	int             pending;
	int             rsp_seen;
	int             cycle_cnt;
	int             n_items;
	int             n_alloc;
	int             n_free;
	int             n_cfg;
	logic           alloc_in_flight;
	// live allocations, used to aim frees at real segments
	logic [3:0]     live_blk[$];
	logic [47:0]    live_off[$];

	best_fit_block_suballocator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	best_fit_block_suballocator_chk u_chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .item(item),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_data(cfg_data), .fail_count(fail_count), .pending(pending),
		.rsp_seen(rsp_seen)
	);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// Watchdog: generous bound on the run, covering each item and its idle gap.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Remember what the block placed so later frees can target it.
	always @(posedge clk) begin
		if (start && !busy) alloc_in_flight <= (item.func == bfbs_pkg::FUNC_ALLOC);
		if (done && alloc_in_flight
			&& (result.status == bfbs_pkg::ST_PLACED
				|| result.status == bfbs_pkg::ST_NEW_BLK)) begin
			live_blk.insert(live_blk.size(), result.block_index);
			live_off.insert(live_off.size(), result.alloc_offset);
		end
	end

	// One item: random idle gap, raise start, hold until accepted.
	task automatic issue(bfbs_pkg::req_t r);
		repeat ($urandom_range(0, 17) * ($urandom_range(0, 3) != 0)) @(posedge clk);
		start <= 1'b1;
		item  <= r;
		do @(posedge clk); while (busy);
		start <= 1'b0;
		item  <= bfbs_pkg::req_t'({$urandom, $urandom, $urandom, $urandom});
		n_items++;
		if (r.func == bfbs_pkg::FUNC_FREE) n_free++; else n_alloc++;
		@(posedge clk);
	endtask

	function automatic bfbs_pkg::req_t mk_alloc(logic [47:0] sz, logic [4:0] al);
		bfbs_pkg::req_t r;
		r = bfbs_pkg::req_t'({$urandom, $urandom, $urandom, $urandom});
		r.func = bfbs_pkg::FUNC_ALLOC; r.req_size = sz; r.align_log2 = al;
		return r;
	endfunction

	function automatic bfbs_pkg::req_t mk_free(logic [3:0] b, logic [47:0] o);
		bfbs_pkg::req_t r;
		r = bfbs_pkg::req_t'({$urandom, $urandom, $urandom, $urandom});
		r.func = bfbs_pkg::FUNC_FREE; r.free_block = b; r.free_offset = o;
		return r;
	endfunction

	// Register writes only with the block drained, plus the end-of-item margin.
	task automatic write_min_size(logic [47:0] v);
		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		n_cfg++;
	endtask

	// Random phase: mostly well-formed alloc/free mixes with a bias to small sizes.
	task automatic random_phase(int n);
		int k;
		logic [47:0] sz;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					sz = (48'({$urandom, $urandom}) >> $urandom_range(0, 47));
					issue(mk_alloc(sz, 5'($urandom_range(0, 12))));
				end
				4: issue(mk_alloc(48'({$urandom, $urandom}), 5'($urandom_range(0, 31))));
				5, 6, 7, 8: begin
					if (live_blk.size() > 0) begin
						k = $urandom_range(0, live_blk.size() - 1);
						issue(mk_free(live_blk[k], live_off[k]));
						live_blk.delete(k);
						live_off.delete(k);
					end else begin
						issue(mk_free(4'($urandom), 48'({$urandom, $urandom})));
					end
				end
				default: issue(mk_free(4'($urandom), 48'({$urandom, $urandom}) >> 30));
			endcase
			// keep the result-driven bookkeeping in step with the requests
			while (pending != 0) @(posedge clk);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		start     = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		item      = '0;
		n_items = 0; n_alloc = 0; n_free = 0; n_cfg = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: free on empty table, zero size, exact fit, alignment extremes,
		// size extremes, coalescing and unknown free.
		issue(mk_free(4'd0, 48'd0));
		issue(mk_alloc(48'd0, 5'd0));
		issue(mk_alloc(48'd100, 5'd4));
		issue(mk_alloc(48'd1, 5'd31));
		issue(mk_alloc(48'hFFFF_FFFF_FFFF, 5'd0));
		issue(mk_alloc(48'd16, 5'd0));
		issue(mk_alloc(48'd16, 5'd0));
		issue(mk_free(4'd0, 48'd16));
		issue(mk_free(4'd0, 48'd16));
		issue(mk_free(4'd0, 48'd0));
		issue(mk_free(4'hF, 48'hFFFF_FFFF_FFFF));
		issue(mk_alloc(48'd16, 5'd0));
		write_min_size(48'd1);
		for (int i = 0; i < 10; i++) issue(mk_alloc(48'd1 << i, 5'd0));
		write_min_size(48'hFFFF_FFFF_FFFF);
		issue(mk_alloc(48'd8, 5'd3));

		// Small blocks fill the table and the block count quickly.
		write_min_size(48'd4096);
		random_phase(130);
		write_min_size(48'd1);
		random_phase(130);
		write_min_size(48'hFFFF_FFFF_FFFF);
		random_phase(130);

		while (pending != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		$display("Covered %0d items (%0d allocate, %0d free), %0d register writes,",
			n_items, n_alloc, n_free, n_cfg);
		$display("%0d results checked against the predicted segment table.", rsp_seen);
		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ----- sim.f -----
hdl/bfbs_pkg.sv
hdl/bfbs_ram.sv
hdl/bfbs_fit.sv
hdl/best_fit_block_suballocator.sv
hdl/bfbs_chk.sv
sim/best_fit_block_suballocator_chk.sv
sim/best_fit_block_suballocator_tb.sv
